// File: hw/rtl/sha256_message_digest_defines.svh
// Assertion macros shared by the digest block's RTL files.
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define SMD_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: assertion failed");

// Check that post holds in the cycle after pre.
`define SMD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: assertion failed");

`endif

// File: hw/rtl/smd_pkg.sv
// Types, constants and helper functions of the SHA-256 digest block.
package smd_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int LEN_POS     = 56;
   localparam int LOAD_LAST   = 16;
   localparam int ROUND_LAST  = 63;
   localparam int WORD_LAST   = 7;
   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef logic [31:0] chain_type [8];

   localparam chain_type INIT_HASH = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_PAD_ONE,
      KIND_PAD_FIRST,
      KIND_PAD_SECOND
   } kind_type;

   typedef struct packed {
      logic start;
      logic load;
      logic round;
      logic fold;
      logic restart;
   } ctrl_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      return (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

endpackage

// File: hw/rtl/smd_block_buffer.sv
// Block buffer memory: sixteen 32-bit words, byte writes, registered word reads.
`include "sha256_message_digest_defines.svh"

module smd_block_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [1:0]  wr_lane,
   input  logic [7:0]  wr_byte,
   input  logic        rd_en,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);
   import smd_pkg::*;

   logic [3:0][7:0] mem [16];
   logic [31:0]     rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][wr_lane] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   `SMD_ASSERT_SAME(a_no_rw_clash, clock, reset, wr_en, !rd_en)

endmodule

// File: hw/rtl/smd_compress.sv
// Compression datapath: chaining words, working variables and schedule window.
module smd_compress (
   input  logic              clock,
   input  logic              reset,
   input  smd_pkg::ctrl_type ctrl,
   input  logic [31:0]       load_word,
   input  logic [5:0]        round_idx,
   output smd_pkg::chain_type chain
);
   import smd_pkg::*;

   chain_type   chain_ff;
   chain_type   work_ff;
   chain_type   work_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_next;
   logic [31:0] ep0, ep1, ch, maj, t1, t2, s0, s1;

   always_comb begin
      ep1 = rotr(work_ff[4], 5'd6) ^ rotr(work_ff[4], 5'd11) ^ rotr(work_ff[4], 5'd25);
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      ep0 = rotr(work_ff[0], 5'd2) ^ rotr(work_ff[0], 5'd13) ^ rotr(work_ff[0], 5'd22);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
          ^ (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + ep1 + ch + ROUND_K[round_idx] + w_ff[0];
      t2  = ep0 + maj;
      work_in[7] = work_ff[6];
      work_in[6] = work_ff[5];
      work_in[5] = work_ff[4];
      work_in[4] = work_ff[3] + t1;
      work_in[3] = work_ff[2];
      work_in[2] = work_ff[1];
      work_in[1] = work_ff[0];
      work_in[0] = t1 + t2;
   end

   always_comb begin
      s0 = rotr(w_ff[1], 5'd7) ^ rotr(w_ff[1], 5'd18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 5'd17) ^ rotr(w_ff[14], 5'd19) ^ (w_ff[14] >> 10);
      w_next = s1 + w_ff[9] + s0 + w_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
      end else if (ctrl.restart) begin
         chain_ff <= INIT_HASH;
      end else if (ctrl.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         work_ff <= chain_ff;
      end else if (ctrl.round) begin
         work_ff <= work_in;
      end
   end

   // advance the schedule window by one word
   always_ff @(posedge clock) begin
      if (ctrl.load || ctrl.round) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= ctrl.load ? load_word : w_next;
      end
   end

   assign chain = chain_ff;

endmodule

// File: hw/rtl/sha256_message_digest.sv
// SHA-256 digest of a byte stream: top level with sequencer and padding.
//
// Requests enter on req_ (valid/stall): one optional message byte and an
// end-of-message flag. A request with a byte that does not complete a
// 64-byte block or end the message leaves the block idle, so bytes
// stream at one per cycle while req_stall is low. A completed block is
// compressed by 16 registered word reads from the block buffer, 64
// rounds of the shared round unit and a fold step, with req_stall high.
// An end request pads in one or two further blocks (two when 56 or more
// bytes of the last block are filled), then drives the eight digest
// words on rsp_, word 0 first, one per cycle while rsp_stall is low.
// A stalled digest word is held; no request is taken until word 7 has
// gone, after which the chaining words and bit count return to their
// initial values. Reset is synchronous and leaves the block idle with
// the initial hash values; the block buffer needs no clearing.
`include "sha256_message_digest_defines.svh"

module sha256_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import smd_pkg::*;

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [6:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        end_ff, end_in;

   logic        req_acc, rsp_acc;
   logic [5:0]  pos;
   logic [5:0]  pad_pos;
   logic        byte_done;
   logic        word_last;
   logic [3:0]  ld_idx;
   logic        mark, with_len;

   logic        wr_en, rd_en;
   logic [31:0] rd_data;
   logic [31:0] load_word;
   ctrl_type    ctrl;
   chain_type   chain;

   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign pos       = bits_ff[8:3];
   assign pad_pos   = req_has_byte ? pos + 6'd1 : pos;
   assign byte_done = req_acc && req_has_byte && pos == 6'(BLOCK_BYTES - 1);
   assign word_last = cnt_ff[2:0] == 3'(WORD_LAST);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (byte_done || req_end_of_message)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cnt_ff == 7'(LOAD_LAST)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (cnt_ff == 7'(ROUND_LAST)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            priority if (kind_ff == KIND_DATA && !end_ff) begin
               state_in = ST_IDLE;
            end else if (kind_ff == KIND_DATA || kind_ff == KIND_PAD_FIRST) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_acc && word_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = state_ff != ST_IDLE;
      rsp_valid    = state_ff == ST_OUT;
      wr_en        = req_acc && req_has_byte;
      rd_en        = state_ff == ST_LOAD && cnt_ff < 7'(LOAD_LAST);
      ctrl.start   = state_ff == ST_LOAD && cnt_ff == 7'd0;
      ctrl.load    = state_ff == ST_LOAD && cnt_ff != 7'd0;
      ctrl.round   = state_ff == ST_ROUND;
      ctrl.fold    = state_ff == ST_FOLD;
      ctrl.restart = rsp_acc && word_last;
   end

   always_comb begin
      cnt_in  = cnt_ff;
      bits_in = bits_ff;
      end_in  = end_ff;
      kind_in = kind_ff;
      fill_in = fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_acc) begin
               if (req_has_byte) begin
                  bits_in = bits_ff + 64'd8;
               end
               priority if (byte_done) begin
                  kind_in = KIND_DATA;
                  fill_in = 7'(BLOCK_BYTES);
                  end_in  = req_end_of_message;
               end else if (req_end_of_message) begin
                  kind_in = (pad_pos < 6'(LEN_POS)) ? KIND_PAD_ONE : KIND_PAD_FIRST;
                  fill_in = {1'b0, pad_pos};
               end else begin
                  end_in = 1'b0;
               end
            end
         end
         ST_LOAD: begin
            cnt_in = (cnt_ff == 7'(LOAD_LAST)) ? '0 : cnt_ff + 7'd1;
         end
         ST_ROUND: begin
            cnt_in = (cnt_ff == 7'(ROUND_LAST)) ? '0 : cnt_ff + 7'd1;
         end
         ST_FOLD: begin
            cnt_in = '0;
            priority if (kind_ff == KIND_DATA) begin
               kind_in = (pos < 6'(LEN_POS)) ? KIND_PAD_ONE : KIND_PAD_FIRST;
               fill_in = {1'b0, pos};
            end else if (kind_ff == KIND_PAD_FIRST) begin
               kind_in = KIND_PAD_SECOND;
               fill_in = '0;
            end else begin
               fill_in = fill_ff;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               cnt_in = cnt_ff + 7'd1;
               if (word_last) begin
                  bits_in = '0;
                  end_in  = 1'b0;
               end
            end
         end
         default: cnt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         bits_ff  <= '0;
         end_ff   <= 1'b0;
         kind_ff  <= KIND_DATA;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bits_ff  <= bits_in;
         end_ff   <= end_in;
         kind_ff  <= kind_in;
         fill_ff  <= fill_in;
      end
   end

   // form the block word: stored bytes, pad mark, zeros, bit length
   assign ld_idx   = 4'(cnt_ff - 7'd1);
   assign mark     = kind_ff == KIND_PAD_ONE || kind_ff == KIND_PAD_FIRST;
   assign with_len = kind_ff == KIND_PAD_ONE || kind_ff == KIND_PAD_SECOND;

   always_comb begin
      logic [6:0] idx;
      load_word = '0;
      for (int b = 0; b < 4; b++) begin
         idx = {1'b0, ld_idx, 2'(b)};
         if (idx < fill_ff) begin
            load_word[8 * (3 - b) +: 8] = rd_data[8 * (3 - b) +: 8];
         end else if (mark && idx == fill_ff) begin
            load_word[8 * (3 - b) +: 8] = PAD_MARK;
         end
      end
      if (with_len && ld_idx == 4'd14) begin
         load_word = bits_ff[63:32];
      end else if (with_len && ld_idx == 4'd15) begin
         load_word = bits_ff[31:0];
      end
   end

   smd_block_buffer u_buffer (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (pos[5:2]),
      .wr_lane (~pos[1:0]),
      .wr_byte (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[3:0]),
      .rd_data (rd_data)
   );

   smd_compress u_compress (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .load_word (load_word),
      .round_idx (cnt_ff[5:0]),
      .chain     (chain)
   );

   assign rsp_digest_word = chain[cnt_ff[2:0]];
   assign rsp_word_index  = cnt_ff[2:0];
   assign rsp_last_word   = word_last;

   `SMD_ASSERT_SAME(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall)
   `SMD_ASSERT_NEXT(a_digest_clears_count, clock, reset, rsp_acc && rsp_last_word, bits_ff == '0 && state_ff == ST_IDLE)
   `SMD_ASSERT_NEXT(a_rounds_then_fold, clock, reset, state_ff == ST_ROUND && cnt_ff == 7'(ROUND_LAST), state_ff == ST_FOLD)

endmodule

// File: tb/tb_sha256_message_digest.sv
// Testbench for the byte-stream SHA-256 digest block, checked against its own predictor.
`timescale 1ns / 1ps

module tb_sha256_message_digest;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HASH_START [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam int BLOCK_LEN  = 64;
   localparam int LENGTH_POS = 56;
   localparam int DIGEST_LEN = 8;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   class digest_scoreboard;
      logic [31:0]     chain [8];
      logic [7:0]      blk [BLOCK_LEN];
      logic [63:0]     bit_count;
      digest_word_type expected_words [$];
      int              errors;
      int              words_checked;
      int              messages;

      function new();
         restart();
         foreach (blk[i]) blk[i] = 8'h00;
         errors        = 0;
         words_checked = 0;
         messages      = 0;
      endfunction

      function void restart();
         chain     = HASH_START;
         bit_count = 64'd0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void compress();
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] s0, s1, t1, t2;
         for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
         for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
         end
         v = chain;
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
      endfunction

      function void note_request(input logic [7:0] data_in, input logic has, input logic eom);
         int              pos;
         logic [63:0]     len;
         digest_word_type e;
         if (has) begin
            pos = int'(bit_count[8:3]);
            blk[pos] = data_in;
            bit_count = bit_count + 64'd8;
            if (pos == BLOCK_LEN - 1)
               compress();
         end
         if (!eom)
            return;
         len = bit_count;
         pos = int'(len[8:3]);
         blk[pos] = 8'h80;
         pos++;
         if (pos > LENGTH_POS) begin
            while (pos < BLOCK_LEN) begin
               blk[pos] = 8'h00;
               pos++;
            end
            compress();
            pos = 0;
         end
         while (pos < LENGTH_POS) begin
            blk[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++)
            blk[LENGTH_POS + i] = len[63 - 8*i -: 8];
         compress();
         for (int i = 0; i < DIGEST_LEN; i++) begin
            e.word  = chain[i];
            e.index = 3'(i);
            e.last  = (i == DIGEST_LEN - 1);
            expected_words.push_back(e);
         end
         restart();
         messages++;
      endfunction

      function void check_word(input logic [31:0] word, input logic [2:0] index,
                               input logic last);
         digest_word_type e;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %b",
                     $time, word, index, last);
            errors++;
            return;
         end
         e = expected_words.pop_front();
         words_checked++;
         if (word !== e.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
            errors++;
         end
         if (index !== e.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.index, index);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last_word expected %b actual %b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        req_has_byte       = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard sb = new();
   int          items_sent  = 0;
   int          burst_left  = 1;
   logic [11:0] stall_cycle = '0;

   sha256_message_digest u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // hold off the digest words in phases: none, random, long runs, light
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_cycle <= '0;
      end else begin
         stall_cycle <= stall_cycle + 1'b1;
         case (stall_cycle[11:10])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 1) == 0);
            2'd2: rsp_stall <= (stall_cycle[3:0] < 4'd11);
            default: rsp_stall <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_word(rsp_digest_word, rsp_word_index, rsp_last_word);
   end

   task automatic send_request(input logic [7:0] data_in, input logic has, input logic eom);
      int gap;
      req_valid          <= 1'b1;
      req_data_byte      <= data_in;
      req_has_byte       <= has;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(data_in, has, eom);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_message(input int len);
      logic        end_on_byte;
      logic [7:0]  data_in;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         // drop in the odd empty request as noise
         if ($urandom_range(0, 9) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         case ($urandom_range(0, 15))
            0: data_in = 8'h00;
            1: data_in = 8'hff;
            default: data_in = 8'($urandom_range(0, 255));
         endcase
         send_request(data_in, 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte)
         send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(8'ha5, 1'b0, 1'b0);
      send_request(8'hff, 1'b0, 1'b1);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'hff, 1'b0, 1'b0);
      send_request(8'h7f, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);

      while (items_sent < 470) begin
         case ($urandom_range(0, 9))
            0, 1, 2: len = $urandom_range(0, 8);
            3, 4, 5, 6: begin
               case ($urandom_range(0, 8))
                  0: len = 54;
                  1: len = 55;
                  2: len = 56;
                  3: len = 57;
                  4: len = 63;
                  5: len = 64;
                  6: len = 65;
                  7: len = 119;
                  default: len = 120;
               endcase
            end
            default: len = $urandom_range(0, 70);
         endcase
         send_message(len);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d requests over %0d messages, checked %0d digest words.",
               items_sent, sb.messages, sb.words_checked);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
